FILE: rtl/fpdf_pkg.sv
// ----------------------------------------------------------------------------
// fpdf_pkg
// Types, constants and the shift-add-3 step for the distance formatter.
// ----------------------------------------------------------------------------
package fpdf_pkg;

   localparam int unsigned VALUE_W    = 16;
   localparam int unsigned BIN_W      = 14;
   localparam int unsigned BCD_W      = 16;
   localparam int unsigned ACC_W      = BCD_W + BIN_W;
   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned NUM_STAGES = 4;

   localparam logic [VALUE_W-1:0] DIST_LIMIT = 16'd9999;

   // conversion steps done between stage k-1 and stage k
   localparam int unsigned DD_ITERS [NUM_STAGES-1] = '{5, 5, 4};
   localparam int unsigned DD_MAX_ITERS            = 5;

   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [ACC_W-1:0]   acc_type;
   typedef logic [BCD_W-1:0]   bcd_type;
   typedef logic [CHAR_W-1:0]  char_type;
   typedef logic [2:0]         pos_type;

   localparam pos_type POS_D0    = 3'd0;
   localparam pos_type POS_POINT = 3'd1;
   localparam pos_type POS_D1    = 3'd2;
   localparam pos_type POS_D2    = 3'd3;
   localparam pos_type POS_D3    = 3'd4;
   localparam pos_type POS_SPACE = 3'd5;
   localparam pos_type POS_C     = 3'd6;
   localparam pos_type POS_M     = 3'd7;

   localparam char_type CHAR_ZERO  = 8'h30;
   localparam char_type CHAR_STAR  = 8'h2A;
   localparam char_type CHAR_POINT = 8'h2E;
   localparam char_type CHAR_SPACE = 8'h20;
   localparam char_type CHAR_C     = 8'h63;
   localparam char_type CHAR_M     = 8'h6D;

   // one double-dabble step: correct every BCD nibble, then shift left
   function automatic acc_type dd_step(input acc_type acc);
      bcd_type bcd;
      bcd = acc[ACC_W-1:BIN_W];
      for (int d = 0; d < BCD_W / 4; d++) begin
         if (bcd[4*d +: 4] >= 4'd5) begin
            bcd[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
         end
      end
      return {bcd[BCD_W-2:0], acc[BIN_W-1:0], 1'b0};
   endfunction

   function automatic acc_type dd_steps(input acc_type acc, input logic [2:0] n);
      acc_type a;
      a = acc;
      for (int i = 0; i < DD_MAX_ITERS; i++) begin
         if (3'(i) < n) begin
            a = dd_step(a);
         end
      end
      return a;
   endfunction

   function automatic char_type digit_char(input logic [3:0] nib, input logic over);
      return over ? CHAR_STAR : (CHAR_ZERO | {4'b0000, nib});
   endfunction

endpackage

FILE: rtl/fixed_point_distance_formatter_unit.sv
// ----------------------------------------------------------------------------
// fixed_point_distance_formatter_unit
// Formats a distance in thousandths as the eight characters "D.DDD cm".
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one 16-bit distance per transfer (thousandths of the unit).
//   rsp_*  : eight character transfers per distance, left to right;
//            rsp_tlast marks the eighth ("m"). Values above 9999 give
//            "*.*** cm".
//   Path: a request passes through one input stage, three conversion
//   stages of 5/5/4 shift-add-3 steps and the character serializer
//   before its first character is valid.
//   Throughput: set by the serializer emitting one character per cycle
//   while rsp_tready is high; up to four further distances queue in the
//   conversion pipeline while it drains.
//   Reset: synchronous, active high; clears all valid flags and the
//   character position, the pipeline comes out empty.
//   Stall: with rsp_tready low the current character holds; the pipeline
//   fills and then deasserts req_tready. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module fixed_point_distance_formatter_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  fpdf_pkg::value_type   req_tdata,   // [15:0] distance_value
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output fpdf_pkg::char_type    rsp_tdata,   // [7:0] character
   output logic                  rsp_tlast    // last_char
);
   import fpdf_pkg::*;

   acc_type  acc_ff  [NUM_STAGES];
   acc_type  acc_in  [NUM_STAGES];
   logic     over_ff [NUM_STAGES];
   logic     vld_ff  [NUM_STAGES];
   logic     go      [NUM_STAGES];

   bcd_type  digits_ff;
   logic     ser_over_ff;
   logic     ser_vld_ff;
   pos_type  pos_ff;
   logic     ser_ready;

   assign ser_ready = !ser_vld_ff || (rsp_tready && (pos_ff == POS_M));

   always_comb begin
      go[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || ser_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         go[k] = !vld_ff[k] || go[k+1];
      end
   end

   assign req_tready = go[0];

   always_comb begin
      acc_in[0] = {{BCD_W{1'b0}}, req_tdata[BIN_W-1:0]};
      for (int k = 1; k < NUM_STAGES; k++) begin
         acc_in[k] = dd_steps(acc_ff[k-1], 3'(DD_ITERS[k-1]));
      end
   end

   always_ff @(posedge clock) begin
      if (go[0]) begin
         acc_ff[0]  <= acc_in[0];
         over_ff[0] <= (req_tdata > DIST_LIMIT);
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (go[k]) begin
            acc_ff[k]  <= acc_in[k];
            over_ff[k] <= over_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         if (go[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NUM_STAGES; k++) begin
            if (go[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ser_ready) begin
         digits_ff   <= acc_ff[NUM_STAGES-1][ACC_W-1:BIN_W];
         ser_over_ff <= over_ff[NUM_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_vld_ff <= 1'b0;
         pos_ff     <= POS_D0;
      end else if (ser_ready) begin
         ser_vld_ff <= vld_ff[NUM_STAGES-1];
         pos_ff     <= POS_D0;
      end else if (rsp_tready) begin
         pos_ff     <= pos_ff + 3'd1;
      end
   end

   always_comb begin
      unique case (pos_ff)
         POS_D0:    rsp_tdata = digit_char(digits_ff[15:12], ser_over_ff);
         POS_POINT: rsp_tdata = CHAR_POINT;
         POS_D1:    rsp_tdata = digit_char(digits_ff[11:8], ser_over_ff);
         POS_D2:    rsp_tdata = digit_char(digits_ff[7:4], ser_over_ff);
         POS_D3:    rsp_tdata = digit_char(digits_ff[3:0], ser_over_ff);
         POS_SPACE: rsp_tdata = CHAR_SPACE;
         POS_C:     rsp_tdata = CHAR_C;
         POS_M:     rsp_tdata = CHAR_M;
      endcase
   end

   assign rsp_tvalid = ser_vld_ff;
   assign rsp_tlast  = (pos_ff == POS_M);

`ifndef NO_ASSERTIONS
   a_text_restarts: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid || (pos_ff == POS_D0))
      else $error("character position did not restart after the last transfer");

   a_stall_holds_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(pos_ff))
      else $error("character position moved while the output was stalled");

   a_backpressure_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> vld_ff[0] && vld_ff[1] && vld_ff[2] && vld_ff[3] && ser_vld_ff)
      else $error("request stalled while the pipeline had room");
`endif

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for fixed_point_distance_formatter_unit.
// Distances go in on the request stream. A predictor works out the
// eight-character "D.DDD cm" text that each one should give, with stars
// above 9999. Each character transfer on the response stream is checked
// against the oldest pending one, along with its tlast flag. Both sides idle
// at random, and one long output hold-off makes the block fill up and stall
// its input.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import fpdf_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN_CYCLES = 24;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      char_type ch;
      logic     last;
   } text_char_type;

   logic      clock      = 1'b0;
   logic      reset      = 1'b1;
   logic      req_tvalid = 1'b0;
   logic      req_tready;
   value_type req_tdata  = '0;
   logic      rsp_tvalid;
   logic      rsp_tready = 1'b0;
   char_type  rsp_tdata;
   logic      rsp_tlast;

   // predictor state
   logic [15:0]   shown_digits = '0;
   logic          shown_over   = 1'b0;
   text_char_type pending_chars [$];

   int          mismatch_count = 0;
   int          idle_cycles    = 0;

   // idling control: sender side is read in the test process, receiver side via NBA
   bit          send_steady = 1'b0;
   bit          recv_steady = 1'b0;
   bit          hold_req    = 1'b0;
   bit          hold_ack    = 1'b0;
   int          hold_left   = 0;
   int unsigned ready_wait  = 0;
   int unsigned ready_draw;

   fixed_point_distance_formatter_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // expected text for one distance; updates the predictor state
   function automatic void predict_text(input value_type dist_val);
      char_type      txt [8];
      char_type      digit_ch [4];
      int unsigned   rest;
      text_char_type t;
      if (dist_val > DIST_LIMIT) begin
         shown_over   = 1'b1;
         shown_digits = '0;
      end else begin
         shown_over = 1'b0;
         rest       = dist_val;
         for (int i = 0; i < 4; i++) begin
            shown_digits[4*i +: 4] = 4'(rest % 10);
            rest = rest / 10;
         end
      end
      for (int i = 0; i < 4; i++) begin
         digit_ch[i] = shown_over ? CHAR_STAR :
                       char_type'(CHAR_ZERO + shown_digits[4*(3-i) +: 4]);
      end
      txt = '{digit_ch[0], CHAR_POINT, digit_ch[1], digit_ch[2], digit_ch[3],
              CHAR_SPACE, CHAR_C, CHAR_M};
      for (int k = 0; k < 8; k++) begin
         t.ch   = txt[k];
         t.last = (k == 7);
         pending_chars.push_back(t);
      end
   endfunction

   task automatic set_idling(input bit steady);
      send_steady = steady;
      recv_steady <= steady;
   endtask

   // one distance transfer; called at a rising edge
   task automatic send_distance(input value_type dist_val);
      int unsigned gap;
      gap = send_steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= value_type'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= dist_val;
      do @(posedge clock); while (!req_tready);
      predict_text(dist_val);
   endtask

   task automatic test_directed_values();
      value_type corner [24] = '{
         16'd0, 16'd1, 16'd5, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999,
         16'd1000, 16'd1234, 16'd4096, 16'd8765, 16'd9998, 16'd9999,
         16'd10000, 16'd10001, 16'd16383, 16'd16384, 16'd32768, 16'h5555,
         16'hAAAA, 16'hFFFF, 16'd7, 16'd5000};
      foreach (corner[i]) begin
         send_distance(corner[i]);
      end
   endtask

   // receiver holds off while the sender keeps offering back to back
   task automatic test_output_backpressure();
      set_idling(1'b1);
      hold_req <= ~hold_req;
      for (int n = 0; n < 16; n++) begin
         send_distance((n % 4 == 3) ? value_type'($urandom_range(10000, 65535)) :
                                      value_type'($urandom_range(0, 9999)));
      end
      set_idling(1'b0);
   endtask

   task automatic test_random_values();
      value_type dist_val;
      for (int n = 0; n < 330; n++) begin
         if (n % 30 == 0) begin
            set_idling($urandom_range(0, 3) == 0);
         end
         case ($urandom_range(0, 9))
            0: dist_val = value_type'($urandom);
            1: dist_val = value_type'($urandom_range(9990, 10010));
            2: dist_val = value_type'($urandom_range(0, 99));
            default: dist_val = value_type'($urandom_range(0, 9999));
         endcase
         send_distance(dist_val);
      end
      set_idling(1'b0);
   endtask

   // response ready: random wait per transfer, plus the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_wait <= 0;
         hold_left  <= 0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_req != hold_ack) begin
         rsp_tready <= 1'b0;
         hold_left  <= LONG_HOLD;
         hold_ack   <= hold_req;
      end else if (ready_wait != 0) begin
         rsp_tready <= 1'b0;
         ready_wait <= ready_wait - 1;
      end else if (rsp_tvalid && rsp_tready) begin
         ready_draw = recv_steady ? 0 : $urandom_range(0, 5);
         rsp_tready <= (ready_draw == 0);
         ready_wait <= (ready_draw == 0) ? 0 : ready_draw - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_chars
      text_char_type got;
      text_char_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ch   = rsp_tdata;
         got.last = rsp_tlast;
         if (pending_chars.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("tb: unexpected transfer char %h last %b", got.ch, got.last);
            end
         end else begin
            want = pending_chars.pop_front();
            if (got.ch !== want.ch || got.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("tb: mismatch char exp %h got %h, last exp %b got %b",
                           want.ch, got.ch, want.last, got.last);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_values();
      test_output_backpressure();
      test_random_values();
      req_tvalid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
